[hw/rtl/sm4ctr_pkg.sv]
// ----------------------------------------------------------------------------
// sm4ctr_pkg
// shared types, constants and round functions of the sm4 counter-mode unit
// ----------------------------------------------------------------------------
package sm4ctr_pkg;

  localparam int unsigned NumRounds = 32;

  typedef logic [31:0] word_t;
  typedef logic [127:0] block_t;

  // data and byte count traveling alongside the round chain
  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  nbytes;
  } side_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  localparam word_t FK0 = 32'ha3b1bac6;
  localparam word_t FK1 = 32'h56aa3350;
  localparam word_t FK2 = 32'h677d9197;
  localparam word_t FK3 = 32'hb27022dc;

  localparam logic [4:0] FullBytes = 5'd16;
  localparam logic [3:0] RegKeyHigh = 4'd0;
  localparam logic [3:0] RegKeyLow  = 4'd1;

  function automatic word_t tau(input word_t a);
    tau = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t lin_round(input word_t b);
    lin_round = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic word_t lin_key(input word_t b);
    lin_key = b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // ck word i: byte j is (4i+j)*7 mod 256
  function automatic word_t ck_word(input logic [4:0] i);
    word_t w;
    logic [7:0] base;
    w = '0;
    base = {1'b0, i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
    end
    ck_word = w;
  endfunction

  // mask keeping the leading n bytes of a word, n saturates at eight
  function automatic logic [63:0] lead_mask(input logic [4:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[63 - 8*b -: 8] = (n > 5'(b)) ? 8'hff : 8'h00;
    end
    lead_mask = m;
  endfunction

endpackage

[hw/rtl/sm4ctr_if.sv]
// ----------------------------------------------------------------------------
// sm4ctr_if
// valid/ready channels of the sm4 counter-mode unit
// ----------------------------------------------------------------------------
interface sm4ctr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [4:0]  valid_bytes;
  logic        load_counter;
  logic [63:0] iv_high;
  logic [63:0] iv_low;
  modport source (output valid, data_high, data_low, valid_bytes, load_counter,
                  iv_high, iv_low, input ready);
  modport sink (input valid, data_high, data_low, valid_bytes, load_counter,
                iv_high, iv_low, output ready);
endinterface

interface sm4ctr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic [4:0]  result_bytes;
  modport source (output valid, result_high, result_low, result_bytes, input ready);
  modport sink (input valid, result_high, result_low, result_bytes, output ready);
endinterface

interface sm4ctr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/sm4ctr_key_cell.sv]
// ----------------------------------------------------------------------------
// sm4ctr_key_cell
// one registered step of the key schedule, stepped during the sweep after reset or a key write
// ----------------------------------------------------------------------------
module sm4ctr_key_cell (
  input  logic              clk,
  input  logic              en,
  input  logic [4:0]        idx,
  input  sm4ctr_pkg::word_t k_in [4],
  output sm4ctr_pkg::word_t k_out [4],
  output sm4ctr_pkg::word_t rk
);
  import sm4ctr_pkg::*;

  word_t nk;
  word_t k_q [3];

  assign nk = k_in[0] ^ lin_key(tau(k_in[1] ^ k_in[2] ^ k_in[3] ^ ck_word(idx)));

  always_ff @(posedge clk) begin
    if (en) begin
      k_q[0] <= k_in[1];
      k_q[1] <= k_in[2];
      k_q[2] <= k_in[3];
      rk     <= nk;
    end
  end

  assign k_out[0] = k_q[0];
  assign k_out[1] = k_q[1];
  assign k_out[2] = k_q[2];
  assign k_out[3] = rk;
endmodule

[hw/rtl/sm4ctr_round_cell.sv]
// ----------------------------------------------------------------------------
// sm4ctr_round_cell
// one registered sm4 round, passes state and side data to the next cell
// ----------------------------------------------------------------------------
module sm4ctr_round_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               vld_in,
  input  sm4ctr_pkg::block_t x_in,
  input  sm4ctr_pkg::side_t  side_in,
  input  sm4ctr_pkg::word_t  rk,
  output logic               vld_out,
  output sm4ctr_pkg::block_t x_out,
  output sm4ctr_pkg::side_t  side_out
);
  import sm4ctr_pkg::*;

  word_t nx;
  assign nx = x_in[127:96] ^ lin_round(tau(x_in[95:64] ^ x_in[63:32] ^ x_in[31:0] ^ rk));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (advance) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_out    <= {x_in[95:0], nx};
      side_out <= side_in;
    end
  end
endmodule

[hw/rtl/sm4_ctr_keystream_cipher_unit.sv]
// ----------------------------------------------------------------------------
// sm4_ctr_keystream_cipher_unit
// sm4 counter-mode keystream cipher, when not stalled one 16-byte block per cycle
// ----------------------------------------------------------------------------
// A request carries one 16-byte block. When load_counter is set the 128-bit
// counter is first taken from iv_high:iv_low. The counter is encrypted with
// sm4 under the configured key, the keystream is xored into the data, bytes
// past valid_bytes read zero (counts above 16 act as 16) and the counter then
// advances by one modulo 2^128. The round chain is a row of 32 round cells,
// one round per cell, so a new request enters every cycle unless the chain is
// stalled or a key sweep runs; a result is offered once its request has passed
// 32 round registers, the first loaded at the accepting edge, and then the
// output register. The whole chain stalls when the output register is full
// and not taken. After a key write the key schedule steps through 32 key cells,
// one per cycle, and ready stays low until that sweep ends (also right after
// reset); configuration writes are expected only while the unit is idle.
module sm4_ctr_keystream_cipher_unit (
  input  logic                clk,
  input  logic                rst,
  sm4ctr_in_if.sink           req,
  sm4ctr_out_if.source        rsp,
  sm4ctr_cfg_if.sink          cfg
);
  import sm4ctr_pkg::*;

  // key registers and counter state
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [63:0] ctr_high;
  logic [63:0] ctr_low;

  // key schedule sweep
  logic [5:0]  ks_count;
  logic        ks_busy;
  word_t       kchain [NumRounds+1][4];
  word_t       rk [NumRounds];

  // round chain
  logic        vld   [NumRounds+1];
  block_t      xs    [NumRounds+1];
  side_t       sides [NumRounds+1];
  logic        advance;

  logic        req_fire;
  logic [63:0] cur_high;
  logic [63:0] cur_low;
  logic [4:0]  nsat;
  logic [127:0] ks;
  logic [4:0]  nlow;

  assign ks_busy   = (ks_count != 6'd0);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      ks_count <= 6'd32;
    end else begin
      if (cfg.valid && cfg.index == RegKeyHigh) begin
        key_high <= cfg.data;
      end
      if (cfg.valid && cfg.index == RegKeyLow) begin
        key_low <= cfg.data;
      end
      // restart the schedule sweep on any key write
      if (cfg.valid && (cfg.index == RegKeyHigh || cfg.index == RegKeyLow)) begin
        ks_count <= 6'd32;
      end else if (ks_busy) begin
        ks_count <= ks_count - 6'd1;
      end
    end
  end

  // each key cell registers its words and hands them to the next cell, so
  // the schedule ripples one cell further per sweep cycle; each cell settles
  // only after all cells before it, and the whole row at the end of the sweep
  assign kchain[0][0] = key_high[63:32] ^ FK0;
  assign kchain[0][1] = key_high[31:0]  ^ FK1;
  assign kchain[0][2] = key_low[63:32]  ^ FK2;
  assign kchain[0][3] = key_low[31:0]   ^ FK3;

  for (genvar i = 0; i < NumRounds; i++) begin : g_key
    sm4ctr_key_cell u_key (
      .clk   (clk),
      .en    (ks_busy),
      .idx   (5'(i)),
      .k_in  (kchain[i]),
      .k_out (kchain[i+1]),
      .rk    (rk[i])
    );
  end

  // ingress: load or keep the counter, advance it once per accepted request
  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance && !ks_busy;
  assign req_fire  = req.valid && req.ready;

  assign cur_high = req.load_counter ? req.iv_high : ctr_high;
  assign cur_low  = req.load_counter ? req.iv_low  : ctr_low;
  assign nsat     = (req.valid_bytes > FullBytes) ? FullBytes : req.valid_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_high <= '0;
      ctr_low  <= '0;
    end else if (req_fire) begin
      {ctr_high, ctr_low} <= {cur_high, cur_low} + 128'd1;
    end
  end

  assign vld[0]   = req_fire;
  assign xs[0]    = {cur_high, cur_low};
  assign sides[0] = '{data_high: req.data_high, data_low: req.data_low, nbytes: nsat};

  for (genvar i = 0; i < NumRounds; i++) begin : g_round
    sm4ctr_round_cell u_round (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .vld_in   (vld[i]),
      .x_in     (xs[i]),
      .side_in  (sides[i]),
      .rk       (rk[i]),
      .vld_out  (vld[i+1]),
      .x_out    (xs[i+1]),
      .side_out (sides[i+1])
    );
  end

  // reverse word order gives the keystream
  assign ks = {xs[NumRounds][31:0], xs[NumRounds][63:32],
               xs[NumRounds][95:64], xs[NumRounds][127:96]};
  assign nlow = (sides[NumRounds].nbytes > 5'd8) ? sides[NumRounds].nbytes - 5'd8 : 5'd0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= vld[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.result_high  <= (sides[NumRounds].data_high ^ ks[127:64])
                          & lead_mask(sides[NumRounds].nbytes);
      rsp.result_low   <= (sides[NumRounds].data_low ^ ks[63:0]) & lead_mask(nlow);
      rsp.result_bytes <= sides[NumRounds].nbytes;
    end
  end
endmodule

[hw/rtl/sm4ctr_checker.sv]
// ----------------------------------------------------------------------------
// sm4ctr_checker
// port-level checks of the sm4 counter-mode unit
// ----------------------------------------------------------------------------
module sm4ctr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_bytes
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_bytes <= 5'd16) else $error("byte count above 16");
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("accept while stalled");
  a_no_early_out: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid) else $error("result right after reset");
endmodule

bind sm4_ctr_keystream_cipher_unit sm4ctr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_bytes (rsp.result_bytes)
);
